/* hdl/c2u_pkg.sv */
// ----------------------------------------------------------------------------
// c2u_pkg
// Shared constants, types and calendar tables for the calendar to Unix seconds
// converter.
// ----------------------------------------------------------------------------
package c2u_pkg;

    // calendar limits
    localparam int unsigned C_UNIX_FIRST_YEAR = 1970;
    localparam int unsigned C_UNIX_LAST_YEAR  = 2106;
    localparam int unsigned C_WDAY_FIRST_YEAR = 2000;
    localparam int unsigned C_WDAY_LAST_YEAR  = 2199;
    localparam int unsigned C_NO_LEAP_YEAR    = 2100;

    // time constants
    localparam int unsigned C_SECS_PER_DAY  = 86400;
    localparam int unsigned C_SECS_PER_HOUR = 3600;
    localparam int unsigned C_SECS_PER_MIN  = 60;
    localparam int unsigned C_DAYS_PER_YEAR = 365;

    // weekday of day zero of the weekday count is saturday: offset before mod 7
    localparam int unsigned C_WDAY_OFFSET = 5;

    // reciprocal of 7 for the mod 7 unit: ceil(2^20 / 7), exact below 2^18
    localparam int unsigned C_MOD7_SHIFT = 20;
    localparam int unsigned C_MOD7_MULT  = ((1 << C_MOD7_SHIFT) + 6) / 7;

    // widths
    localparam int unsigned C_DAYS_W = 17;
    localparam int unsigned C_TOD_W  = 17;
    localparam int unsigned C_SECS_W = 33;

    // decoded date between the first and second stage
    typedef struct packed {
        logic                valid;
        logic                unix_range;
        logic                wday_range;
        logic [C_DAYS_W-1:0] days_unix;
        logic [C_DAYS_W-1:0] days_wday;
        logic [C_TOD_W-1:0]  tod_secs;
    } t_c2u_date;

    // days in the year before the first of a month, month 1..12
    function automatic logic [8:0] days_before_month(input logic [3:0] month);
        logic [8:0] days;
        case (month)
            4'd1:    days = 9'd0;
            4'd2:    days = 9'd31;
            4'd3:    days = 9'd59;
            4'd4:    days = 9'd90;
            4'd5:    days = 9'd120;
            4'd6:    days = 9'd151;
            4'd7:    days = 9'd181;
            4'd8:    days = 9'd212;
            4'd9:    days = 9'd243;
            4'd10:   days = 9'd273;
            4'd11:   days = 9'd304;
            4'd12:   days = 9'd334;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

    // length of a month, 0 for a month number out of range
    function automatic logic [4:0] month_length(input logic [3:0] month,
                                                input logic       leap);
        logic [4:0] len;
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:    len = leap ? 5'd29 : 5'd28;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

/* hdl/calendar_to_unix_seconds.sv */
// ----------------------------------------------------------------------------
// calendar_to_unix_seconds
// Converts a calendar date and time of day to a 32-bit Unix seconds count, a
// validity flag and the weekday (1 = monday .. 7 = sunday).
//
//   channel   direction  handshake         payload
//   request   in         i_valid/o_stall   year, month, day, hour, minute, second
//   result    out        o_valid/i_stall   datetime_valid, unix_seconds, weekday
//
// One request per cycle while the result channel is not stalled; a request passes
// through an input register, a stage for the day counts (multiply by 365), and the result
// register fed by the multiply by 86400 and the mod 7 reciprocal multiply.
// Reset clears the stage valids only. A stalled result holds the pipeline
// from the back; empty stages keep accepting while the output waits.
// ----------------------------------------------------------------------------
module calendar_to_unix_seconds (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_year_value,
    input  logic [7:0]  i_month_value,
    input  logic [7:0]  i_day_value,
    input  logic [7:0]  i_hour_value,
    input  logic [7:0]  i_minute_value,
    input  logic [7:0]  i_second_value,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_datetime_valid,
    output logic [31:0] o_unix_seconds,
    output logic [2:0]  o_weekday_number
);

    localparam int unsigned C_MOD7_PROD_W = c2u_pkg::C_DAYS_W + 18;

    // stage valids
    logic r_s1_valid;
    logic r_s2_valid;
    logic r_out_valid;

    // input register
    logic [15:0] r_year;
    logic [7:0]  r_month;
    logic [7:0]  r_day;
    logic [7:0]  r_hour;
    logic [7:0]  r_minute;
    logic [7:0]  r_second;

    // day count register and result register
    c2u_pkg::t_c2u_date r_date;
    c2u_pkg::t_c2u_date n_date;
    logic               r_dt_valid;
    logic [31:0]        r_unix;
    logic [2:0]         r_wday;

    logic                          out_free;
    logic                          s2_free;
    logic                          s1_free;
    logic [c2u_pkg::C_SECS_W-1:0]  secs_sum;
    logic [c2u_pkg::C_DAYS_W-1:0]  wday_days;
    logic [C_MOD7_PROD_W-1:0]      mod7_prod;
    logic [c2u_pkg::C_DAYS_W-1:0]  mod7_quot;
    logic [c2u_pkg::C_DAYS_W-1:0]  mod7_rem;
    logic [31:0]                   n_unix;
    logic [2:0]                    n_wday;

    // pipeline flow: a stage loads when it is empty or its content moves on
    assign out_free = !r_out_valid || !i_stall;
    assign s2_free  = !r_s2_valid || out_free;
    assign s1_free  = !r_s1_valid || s2_free;
    assign o_stall  = !s1_free;

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= i_valid;
            end
            if (s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
            if (out_free) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (s1_free && i_valid) begin
            r_year   <= i_year_value;
            r_month  <= i_month_value;
            r_day    <= i_day_value;
            r_hour   <= i_hour_value;
            r_minute <= i_minute_value;
            r_second <= i_second_value;
        end
    end

    // range checks and day counts
    c2u_date_calc u_date_calc (
        .i_year   (r_year),
        .i_month  (r_month),
        .i_day    (r_day),
        .i_hour   (r_hour),
        .i_minute (r_minute),
        .i_second (r_second),
        .o_date   (n_date)
    );

    always_ff @(posedge i_clk) begin
        if (s2_free && r_s1_valid) begin
            r_date <= n_date;
        end
    end

    // seconds since the epoch, overflow shows in the top bit
    assign secs_sum = c2u_pkg::C_SECS_W'(r_date.days_unix)
                    * c2u_pkg::C_SECS_W'(c2u_pkg::C_SECS_PER_DAY)
                    + c2u_pkg::C_SECS_W'(r_date.tod_secs);

    assign n_unix = (r_date.valid && r_date.unix_range && !secs_sum[c2u_pkg::C_SECS_W-1])
                  ? secs_sum[31:0] : 32'd0;

    // weekday: (days + 5) mod 7 through a reciprocal multiply
    assign wday_days = r_date.days_wday + c2u_pkg::C_DAYS_W'(c2u_pkg::C_WDAY_OFFSET);
    assign mod7_prod = C_MOD7_PROD_W'(wday_days) * C_MOD7_PROD_W'(c2u_pkg::C_MOD7_MULT);
    assign mod7_quot = c2u_pkg::C_DAYS_W'(mod7_prod >> c2u_pkg::C_MOD7_SHIFT);
    assign mod7_rem  = wday_days - c2u_pkg::C_DAYS_W'(mod7_quot * c2u_pkg::C_DAYS_W'(7));

    assign n_wday = (r_date.valid && r_date.wday_range) ? (mod7_rem[2:0] + 3'd1) : 3'd0;

    // result register
    always_ff @(posedge i_clk) begin
        if (out_free && r_s2_valid) begin
            r_dt_valid <= r_date.valid;
            r_unix     <= n_unix;
            r_wday     <= n_wday;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_datetime_valid = r_dt_valid;
    assign o_unix_seconds   = r_unix;
    assign o_weekday_number = r_wday;

endmodule

/* hdl/c2u_date_calc.sv */
// ----------------------------------------------------------------------------
// c2u_date_calc
// Range checks and closed-form day counts for one calendar request: days since
// 1970-01-01, days since 2000-01-01 and seconds into the day.
// ----------------------------------------------------------------------------
module c2u_date_calc (
    input  logic [15:0]          i_year,
    input  logic [7:0]           i_month,
    input  logic [7:0]           i_day,
    input  logic [7:0]           i_hour,
    input  logic [7:0]           i_minute,
    input  logic [7:0]           i_second,
    output c2u_pkg::t_c2u_date   o_date
);

    logic        leap;
    logic        after_skip;
    logic        month_ok;
    logic [3:0]  month_idx;
    logic [4:0]  month_len;
    logic [8:0]  day_of_year;
    logic [15:0] year_off_unix;
    logic [15:0] year_off_wday;
    logic [7:0]  k_unix;
    logic [7:0]  k_wday;
    logic [6:0]  leaps_unix;
    logic [6:0]  leaps_wday;

    // leap rule: divisible by 4, except the one skipped year
    assign leap       = (i_year[1:0] == 2'b00) && (i_year != 16'(c2u_pkg::C_NO_LEAP_YEAR));
    assign after_skip = i_year > 16'(c2u_pkg::C_NO_LEAP_YEAR);

    // field range checks
    assign month_ok  = (i_month >= 8'd1) && (i_month <= 8'd12);
    assign month_idx = month_ok ? i_month[3:0] : 4'd0;
    assign month_len = c2u_pkg::month_length(month_idx, leap);

    assign o_date.valid = month_ok && (i_day >= 8'd1) && (i_day <= {3'b000, month_len})
                       && (i_hour < 8'd24) && (i_minute < 8'd60) && (i_second < 8'd60);

    assign o_date.unix_range = (i_year >= 16'(c2u_pkg::C_UNIX_FIRST_YEAR))
                            && (i_year <= 16'(c2u_pkg::C_UNIX_LAST_YEAR));
    assign o_date.wday_range = (i_year >= 16'(c2u_pkg::C_WDAY_FIRST_YEAR))
                            && (i_year <= 16'(c2u_pkg::C_WDAY_LAST_YEAR));

    // day within the year, extra day after february of a leap year
    assign day_of_year = c2u_pkg::days_before_month(month_idx) + {1'b0, i_day} - 9'd1
                       + {8'd0, (month_idx > 4'd2) && leap};

    // year offsets, only meaningful inside their ranges
    assign year_off_unix = i_year - 16'(c2u_pkg::C_UNIX_FIRST_YEAR);
    assign year_off_wday = i_year - 16'(c2u_pkg::C_WDAY_FIRST_YEAR);
    assign k_unix        = year_off_unix[7:0];
    assign k_wday        = year_off_wday[7:0];

    // leap days passed since the base year (1972 and 2000 are multiples of 4)
    assign leaps_unix = 7'(({1'b0, k_unix} + 9'd1) >> 2) - {6'd0, after_skip};
    assign leaps_wday = 7'(({1'b0, k_wday} + 9'd3) >> 2) - {6'd0, after_skip};

    // elapsed days since each base date
    assign o_date.days_unix = c2u_pkg::C_DAYS_W'(k_unix) * c2u_pkg::C_DAYS_W'(c2u_pkg::C_DAYS_PER_YEAR)
                            + c2u_pkg::C_DAYS_W'(leaps_unix) + c2u_pkg::C_DAYS_W'(day_of_year);
    assign o_date.days_wday = c2u_pkg::C_DAYS_W'(k_wday) * c2u_pkg::C_DAYS_W'(c2u_pkg::C_DAYS_PER_YEAR)
                            + c2u_pkg::C_DAYS_W'(leaps_wday) + c2u_pkg::C_DAYS_W'(day_of_year);

    // seconds into the day
    assign o_date.tod_secs =
          c2u_pkg::C_TOD_W'(i_hour[4:0])   * c2u_pkg::C_TOD_W'(c2u_pkg::C_SECS_PER_HOUR)
        + c2u_pkg::C_TOD_W'(i_minute[5:0]) * c2u_pkg::C_TOD_W'(c2u_pkg::C_SECS_PER_MIN)
        + c2u_pkg::C_TOD_W'(i_second[5:0]);

endmodule
